>>> design/cnns_pkg.sv
// Shared constants, codes and types for the cosine nearest neighbor search block.
`default_nettype none

package cnns_pkg;

    // Storage geometry
    localparam int MAX_ENTRIES  = 1024;
    localparam int MAX_DIM      = 512;
    localparam int ELEMENT_BITS = 16;

    localparam int ENTRY_BITS = $clog2(MAX_ENTRIES);
    localparam int POS_BITS   = $clog2(MAX_DIM);
    localparam int DB_ADDR_BITS = ENTRY_BITS + POS_BITS;

    // Configuration register widths
    localparam int THR_BITS  = 16;
    localparam int NENT_BITS = 11;
    localparam int NDIM_BITS = 10;
    localparam int CFG_DATA_BITS  = 16;
    localparam int CFG_INDEX_BITS = 2;

    // Arithmetic
    localparam int PROD_BITS = 2 * ELEMENT_BITS;
    localparam int ACC_BITS  = 41;
    localparam int FRAC_BITS = 2 * (ELEMENT_BITS - 1);
    localparam int THR_SHIFT = FRAC_BITS - 15;

    localparam logic signed [ACC_BITS-1:0] ACC_MAX   = {1'b0, {(ACC_BITS-1){1'b1}}};
    localparam logic signed [ACC_BITS-1:0] ACC_MIN   = {1'b1, {(ACC_BITS-1){1'b0}}};
    localparam logic signed [ACC_BITS-1:0] MINUS_ONE = -(ACC_BITS'(1) <<< FRAC_BITS);

    // Reset values of the configuration registers
    localparam logic signed [THR_BITS-1:0] THR_RESET  = 16'sd13107;
    localparam logic [NENT_BITS-1:0]       NENT_RESET = NENT_BITS'(MAX_ENTRIES);
    localparam logic [NDIM_BITS-1:0]       NDIM_RESET = NDIM_BITS'(MAX_DIM);

    // Stream packing
    localparam int IN_DATA_BITS  = 40;  // entry, position, element = 35 bits
    localparam int OUT_DATA_BITS = 56;  // best_index, best_score = 51 bits

    // Command codes on the input tuser
    localparam logic CMD_DB    = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_THRESHOLD = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ENTRIES   = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DIMS      = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } state_t;

endpackage : cnns_pkg

`default_nettype wire

>>> design/cosine_nearest_neighbor_search.sv
// Top level: brute force cosine nearest neighbor search over a vector memory.
`default_nettype none

// Channel   Direction  Payload                                         Transfer
// s_axis    in         tdata: entry[9:0] position[18:10] element[34:19] tvalid & tready
//                      tuser: cmd   tlast: last
// m_axis    out        tdata: best_index[9:0] best_score[50:10]         tvalid & tready
//                      tuser: found
// cfg       in         cfg_index selects threshold/entries/dims          cfg_en high
//
// A database or query element is written as its transfer is taken; the input is ready
// every cycle while idle. A query transfer with tlast starts a search that reads one
// database element per cycle from the single read port of the vector memory, so the
// input stalls until the result is loaded into the output register, longer while an
// earlier result still waits in the output register.
// The result sits in an output register; element writes are taken while it waits.
// Reset clears control state and loads the configuration defaults; the memories
// need no clearing pass.

module cosine_nearest_neighbor_search
    import cnns_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    // input stream
    input  wire logic                      s_axis_tvalid,
    output logic                           s_axis_tready,
    input  wire logic [IN_DATA_BITS-1:0]   s_axis_tdata,   // entry, position, element, zero pad
    input  wire logic                      s_axis_tuser,   // cmd
    input  wire logic                      s_axis_tlast,   // last
    // result stream
    output logic                           m_axis_tvalid,
    input  wire logic                      m_axis_tready,
    output logic [OUT_DATA_BITS-1:0]       m_axis_tdata,   // best_index, best_score, zero pad
    output logic                           m_axis_tuser,   // found
    // configuration writes
    input  wire logic                      cfg_en,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  cfg_data
);

    // ------------------------------------------------------------------
    // Input field unpacking
    // ------------------------------------------------------------------
    logic [ENTRY_BITS-1:0]          in_entry;
    logic [POS_BITS-1:0]            in_pos;
    logic signed [ELEMENT_BITS-1:0] in_elem;
    logic                           in_xfer;

    assign in_entry = s_axis_tdata[ENTRY_BITS-1:0];
    assign in_pos   = s_axis_tdata[ENTRY_BITS +: POS_BITS];
    assign in_elem  = s_axis_tdata[DB_ADDR_BITS +: ELEMENT_BITS];
    assign in_xfer  = s_axis_tvalid && s_axis_tready;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [THR_BITS-1:0] thr_reg;
    logic [NENT_BITS-1:0]       nent_cfg_reg;
    logic [NDIM_BITS-1:0]       ndim_cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg      <= THR_RESET;
            nent_cfg_reg <= NENT_RESET;
            ndim_cfg_reg <= NDIM_RESET;
        end
        else if (cfg_en)
        begin
            unique case (cfg_index)
                REG_THRESHOLD: thr_reg      <= cfg_data[THR_BITS-1:0];
                REG_ENTRIES:   nent_cfg_reg <= cfg_data[NENT_BITS-1:0];
                REG_DIMS:      ndim_cfg_reg <= cfg_data[NDIM_BITS-1:0];
                default:       ;
            endcase
        end
    end

    // Saturate the counts to the memory geometry
    logic [NENT_BITS-1:0] n_ent;
    logic [NDIM_BITS-1:0] n_dim;
    logic [NENT_BITS-1:0] n_ent_m1;
    logic [NDIM_BITS-1:0] n_dim_m1;

    assign n_ent    = (nent_cfg_reg > NENT_BITS'(MAX_ENTRIES)) ? NENT_BITS'(MAX_ENTRIES)
                                                               : nent_cfg_reg;
    assign n_dim    = (ndim_cfg_reg > NDIM_BITS'(MAX_DIM)) ? NDIM_BITS'(MAX_DIM) : ndim_cfg_reg;
    assign n_ent_m1 = n_ent - NENT_BITS'(1);
    assign n_dim_m1 = n_dim - NDIM_BITS'(1);

    // Threshold moved to the score's fraction position
    logic signed [ACC_BITS-1:0] thr_scaled;
    assign thr_scaled = ACC_BITS'(thr_reg) <<< THR_SHIFT;

    // ------------------------------------------------------------------
    // Control: walk entries and dimensions, one element read per cycle
    // ------------------------------------------------------------------
    state_t                state_reg, state_next;
    logic [ENTRY_BITS-1:0] ent_cnt_reg, ent_cnt_next;
    logic [POS_BITS-1:0]   dim_cnt_reg, dim_cnt_next;

    logic start;        // query element with tlast accepted
    logic trivial;      // nothing to read: no entries or no dimensions
    logic last_dim;
    logic last_ent;
    logic pipe_empty;
    logic out_free;
    logic load_out;

    logic v1_reg, v2_reg, done3_reg;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign start    = in_xfer && (s_axis_tuser == CMD_QUERY) && s_axis_tlast;
    assign trivial  = (n_ent == '0) || (n_dim == '0);
    assign last_dim = ({1'b0, dim_cnt_reg} == n_dim_m1);
    assign last_ent = ({1'b0, ent_cnt_reg} == n_ent_m1);
    assign pipe_empty = !v1_reg && !v2_reg && !done3_reg;
    assign out_free   = !m_axis_tvalid || m_axis_tready;

    always_comb
    begin
        state_next   = state_reg;
        ent_cnt_next = ent_cnt_reg;
        dim_cnt_next = dim_cnt_reg;
        load_out     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    ent_cnt_next = '0;
                    dim_cnt_next = '0;
                    state_next   = trivial ? ST_DRAIN : ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (last_dim)
                begin
                    dim_cnt_next = '0;
                    ent_cnt_next = ent_cnt_reg + ENTRY_BITS'(1);
                    if (last_ent)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
                else
                begin
                    dim_cnt_next = dim_cnt_reg + POS_BITS'(1);
                end
            end
            ST_DRAIN:
            begin
                // hold until the last score is compared and the output slot is free
                if (pipe_empty && out_free)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            ent_cnt_reg <= '0;
            dim_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            ent_cnt_reg <= ent_cnt_next;
            dim_cnt_reg <= dim_cnt_next;
        end
    end

    // ------------------------------------------------------------------
    // Vector memories: one write port, one registered read port each
    // ------------------------------------------------------------------
    logic signed [ELEMENT_BITS-1:0] db_mem [MAX_ENTRIES*MAX_DIM];
    logic signed [ELEMENT_BITS-1:0] q_mem  [MAX_DIM];
    logic signed [ELEMENT_BITS-1:0] db_rd_reg;
    logic signed [ELEMENT_BITS-1:0] q_rd_reg;

    always_ff @(posedge clk)
    begin
        if (in_xfer && (s_axis_tuser == CMD_DB))
        begin
            db_mem[{in_entry, in_pos}] <= in_elem;
        end
        db_rd_reg <= db_mem[{ent_cnt_reg, dim_cnt_reg}];
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer && (s_axis_tuser == CMD_QUERY))
        begin
            q_mem[in_pos] <= in_elem;
        end
        q_rd_reg <= q_mem[dim_cnt_reg];
    end

    // ------------------------------------------------------------------
    // Datapath: read -> multiply -> accumulate -> compare
    // ------------------------------------------------------------------
    logic                         first1_reg, lastd1_reg;
    logic [ENTRY_BITS-1:0]        ent1_reg;
    logic                         first2_reg, lastd2_reg;
    logic [ENTRY_BITS-1:0]        ent2_reg;
    logic signed [PROD_BITS-1:0]  prod_reg;
    logic [ENTRY_BITS-1:0]        ent3_reg;
    logic signed [ACC_BITS-1:0]   acc_reg;

    logic signed [ACC_BITS:0]     acc_sum;
    logic signed [ACC_BITS-1:0]   acc_sat;

    assign acc_sum = (ACC_BITS+1)'(acc_reg) + (ACC_BITS+1)'(prod_reg);
    always_comb
    begin
        if (acc_sum > (ACC_BITS+1)'(ACC_MAX))
        begin
            acc_sat = ACC_MAX;
        end
        else if (acc_sum < (ACC_BITS+1)'(ACC_MIN))
        begin
            acc_sat = ACC_MIN;
        end
        else
        begin
            acc_sat = acc_sum[ACC_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            done3_reg <= 1'b0;
        end
        else
        begin
            v1_reg    <= (state_reg == ST_RUN);
            v2_reg    <= v1_reg;
            done3_reg <= v2_reg && lastd2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        // tags that travel with the read
        first1_reg <= (dim_cnt_reg == '0);
        lastd1_reg <= last_dim;
        ent1_reg   <= ent_cnt_reg;
        // product stage
        first2_reg <= first1_reg;
        lastd2_reg <= lastd1_reg;
        ent2_reg   <= ent1_reg;
        prod_reg   <= PROD_BITS'(db_rd_reg) * PROD_BITS'(q_rd_reg);
        // accumulate stage; restart on the first dimension of each entry
        if (v2_reg)
        begin
            acc_reg  <= first2_reg ? ACC_BITS'(prod_reg) : acc_sat;
            ent3_reg <= ent2_reg;
        end
    end

    // Running best: strict compare against both the best so far and the threshold
    logic signed [ACC_BITS-1:0] best_reg;
    logic [ENTRY_BITS-1:0]      best_idx_reg;
    logic                       found_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_reg     <= MINUS_ONE;
            best_idx_reg <= '0;
            found_reg    <= 1'b0;
        end
        else if (start)
        begin
            // with no dimensions every entry scores zero; entry 0 alone can win
            if ((n_ent != '0) && (n_dim == '0) && thr_reg[THR_BITS-1])
            begin
                best_reg  <= '0;
                found_reg <= 1'b1;
            end
            else
            begin
                best_reg  <= MINUS_ONE;
                found_reg <= 1'b0;
            end
            best_idx_reg <= '0;
        end
        else if (done3_reg && (acc_reg > best_reg) && (acc_reg > thr_scaled))
        begin
            best_reg     <= acc_reg;
            best_idx_reg <= ent3_reg;
            found_reg    <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic                       out_valid_reg;
    logic [ENTRY_BITS-1:0]      out_idx_reg;
    logic signed [ACC_BITS-1:0] out_score_reg;
    logic                       out_found_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            // zero the payload when nothing qualified
            out_found_reg <= found_reg;
            out_idx_reg   <= found_reg ? best_idx_reg : '0;
            out_score_reg <= found_reg ? best_reg : '0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_found_reg;
    assign m_axis_tdata  = {{(OUT_DATA_BITS-ENTRY_BITS-ACC_BITS){1'b0}},
                            out_score_reg, out_idx_reg};

endmodule : cosine_nearest_neighbor_search

`default_nettype wire

>>> sim/tb_top.sv
// Self-checking testbench for the cosine nearest neighbor search block.
`timescale 1ns / 100ps

module tb_top;
    import cnns_pkg::*;

    localparam int CLK_HALF       = 10;
    localparam int RESET_CYCLES   = 9;
    localparam int STALL_LIMIT    = 40000;  // cycles with no transfer before giving up
    localparam int SETTLE_CYCLES  = 16;     // idle cycles ahead of a register write
    localparam int TAIL_CYCLES    = 64;
    localparam int NUM_PHASES     = 12;
    localparam int PRESSURE_PHASE = 4;
    localparam int PAUSE_PHASE    = 9;
    localparam int HOLD_CYCLES    = 3000;
    localparam int MAX_REPORTS    = 10;

    // One element write as it travels on the input stream.
    typedef struct packed {
        logic                           cmd;
        logic [ENTRY_BITS-1:0]          entry;
        logic [POS_BITS-1:0]            position;
        logic signed [ELEMENT_BITS-1:0] element;
        logic                           last;
    } vec_write_t;

    // One search answer as it travels on the result stream.
    typedef struct packed {
        logic [ENTRY_BITS-1:0]      best_index;
        logic                       found;
        logic signed [ACC_BITS-1:0] best_score;
    } match_t;

    typedef enum logic { ROW_CFG, ROW_XFER } row_kind_t;

    typedef struct packed {
        row_kind_t                 kind;
        logic [CFG_INDEX_BITS-1:0] reg_index;
        logic [CFG_DATA_BITS-1:0]  reg_value;
        vec_write_t                xfer;
        bit                        typed;   // want holds a hand-computed answer
        match_t                    want;
    } stim_row_t;

    localparam match_t NO_MATCH = '0;

    logic                      clk;
    logic                      rst_n;
    logic                      s_axis_tvalid;
    logic                      s_axis_tready;
    logic [IN_DATA_BITS-1:0]   s_axis_tdata;
    logic                      s_axis_tuser;
    logic                      s_axis_tlast;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready;
    logic [OUT_DATA_BITS-1:0]  m_axis_tdata;
    logic                      m_axis_tuser;
    logic                      cfg_en;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    cosine_nearest_neighbor_search u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // entry, position, element, zero pad
        .s_axis_tuser  (s_axis_tuser),   // cmd
        .s_axis_tlast  (s_axis_tlast),   // last
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // best_index, best_score, zero pad
        .m_axis_tuser  (m_axis_tuser),   // found
        .cfg_en        (cfg_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Shadow copy of the vector memory, the query and the registers.
    // The loaded flags keep every search inside the written region.
    logic signed [ELEMENT_BITS-1:0] db_shadow [MAX_ENTRIES][MAX_DIM];
    bit [MAX_DIM-1:0]               db_loaded [MAX_ENTRIES];
    logic signed [ELEMENT_BITS-1:0] query_shadow [MAX_DIM];
    bit [MAX_DIM-1:0]               query_loaded;
    logic signed [THR_BITS-1:0]     thr_shadow;
    logic [NENT_BITS-1:0]           nent_shadow;
    logic [NDIM_BITS-1:0]           ndim_shadow;

    match_t    pending_matches[$];   // answers still owed by the block, oldest first
    stim_row_t directed_rows[$];

    int mismatch_count;
    int report_count;
    int tx_idle_pct;
    int rx_stall_pct;
    int rx_hold;                     // receiver hold-off, counted down by the receiver

    // ---------------------------------------------------------------- clock
    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // ---------------------------------------------------------------- predictor
    function automatic int active_entries();
        return (nent_shadow > MAX_ENTRIES) ? MAX_ENTRIES : int'(nent_shadow);
    endfunction

    function automatic int active_dims();
        return (ndim_shadow > MAX_DIM) ? MAX_DIM : int'(ndim_shadow);
    endfunction

    function automatic void apply_reg(logic [CFG_INDEX_BITS-1:0] idx,
                                      logic [CFG_DATA_BITS-1:0] value);
        case (idx)
            REG_THRESHOLD: thr_shadow  = value[THR_BITS-1:0];
            REG_ENTRIES:   nent_shadow = value[NENT_BITS-1:0];
            REG_DIMS:      ndim_shadow = value[NDIM_BITS-1:0];
            default:       ;
        endcase
    endfunction

    // Store the element; on a query element with last, walk the entries in order
    // and keep the first one that strictly beats both the running best and the
    // threshold. Returns 1 when the transfer owes an answer.
    function automatic bit nearest_match(input vec_write_t w, output match_t m);
        int     n_ent;
        int     n_dim;
        int     best_e;
        bit     hit;
        longint acc;
        longint best;
        longint thr_q30;
        m = NO_MATCH;
        if (w.cmd == CMD_DB)
        begin
            db_shadow[w.entry][w.position] = w.element;
            db_loaded[w.entry][w.position] = 1'b1;
            return 1'b0;
        end
        query_shadow[w.position] = w.element;
        query_loaded[w.position] = 1'b1;
        if (!w.last)
            return 1'b0;
        n_ent   = active_entries();
        n_dim   = active_dims();
        thr_q30 = longint'(thr_shadow) <<< THR_SHIFT;
        best    = longint'(MINUS_ONE);
        best_e  = 0;
        hit     = 1'b0;
        for (int e = 0; e < n_ent; e++)
        begin
            acc = 0;
            for (int d = 0; d < n_dim; d++)
            begin
                acc = acc + longint'(db_shadow[e][d]) * longint'(query_shadow[d]);
                // saturate to the accumulator range after every add
                if (acc > longint'(ACC_MAX))
                    acc = longint'(ACC_MAX);
                else if (acc < longint'(ACC_MIN))
                    acc = longint'(ACC_MIN);
            end
            if (acc > best && acc > thr_q30)
            begin
                best   = acc;
                best_e = e;
                hit    = 1'b1;
            end
        end
        if (hit)
        begin
            m.best_index = ENTRY_BITS'(best_e);
            m.found      = 1'b1;
            m.best_score = ACC_BITS'(best);
        end
        return 1'b1;
    endfunction

    // ---------------------------------------------------------------- table helpers
    function automatic match_t found_at(int idx, longint score);
        match_t m;
        m.best_index = ENTRY_BITS'(idx);
        m.found      = 1'b1;
        m.best_score = ACC_BITS'(score);
        return m;
    endfunction

    function automatic stim_row_t reg_row(logic [CFG_INDEX_BITS-1:0] idx,
                                          logic [CFG_DATA_BITS-1:0] value);
        stim_row_t r;
        r = '0;
        r.kind      = ROW_CFG;
        r.reg_index = idx;
        r.reg_value = value;
        return r;
    endfunction

    function automatic stim_row_t xfer_row(logic cmd, int entry, int pos, int el,
                                           logic last, bit typed, match_t want);
        stim_row_t r;
        r = '0;
        r.kind          = ROW_XFER;
        r.xfer.cmd      = cmd;
        r.xfer.entry    = ENTRY_BITS'(entry);
        r.xfer.position = POS_BITS'(pos);
        r.xfer.element  = ELEMENT_BITS'(el);
        r.xfer.last     = last;
        r.typed         = typed;
        r.want          = want;
        return r;
    endfunction

    // Append one row to the directed table.
    function automatic void add_row(stim_row_t r);
        directed_rows = {directed_rows, r};
    endfunction

    // Bias toward the corners of Q1.15 now and then.
    function automatic logic signed [ELEMENT_BITS-1:0] random_element();
        case ($urandom_range(15))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return 16'sh0000;
            3:       return 16'shFFFF;
            default: return ELEMENT_BITS'($urandom);
        endcase
    endfunction

    // ---------------------------------------------------------------- input driver
    // Insert random idle cycles, offer the write at the falling edge, hold it
    // until the transfer, then record what the block owes for it.
    task automatic issue(input vec_write_t w, input bit typed, input match_t want);
        match_t predicted;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_DATA_BITS'({w.element, w.position, w.entry});
        s_axis_tuser  <= w.cmd;
        s_axis_tlast  <= w.last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (nearest_match(w, predicted))
            pending_matches = {pending_matches, (typed ? want : predicted)};
    endtask

    // Drop valid, wait out every owed answer, then let the block settle.
    task automatic quiesce();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_matches.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] value);
        @(negedge clk);
        cfg_en    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_en    <= 1'b0;
        apply_reg(idx, value);
    endtask

    // Load every database and query element the next search can touch.
    task automatic fill_region();
        vec_write_t w;
        for (int e = 0; e < active_entries(); e++)
            for (int d = 0; d < active_dims(); d++)
                if (!db_loaded[e][d])
                begin
                    w = '{CMD_DB, ENTRY_BITS'(e), POS_BITS'(d), random_element(), 1'b0};
                    issue(w, 1'b0, NO_MATCH);
                end
        for (int d = 0; d < active_dims(); d++)
            if (!query_loaded[d])
            begin
                w = '{CMD_QUERY, ENTRY_BITS'($urandom), POS_BITS'(d), random_element(), 1'b0};
                issue(w, 1'b0, NO_MATCH);
            end
    endtask

    // Mostly writes inside the searched region and searches; the rest is noise
    // with every field random. The region stays loaded, so any search is legal.
    task automatic random_traffic(input int budget, input int search_pct, input bit pause);
        int         pick;
        vec_write_t w;
        for (int k = 0; k < budget; k++)
        begin
            if (pause && k == budget / 2)
                quiesce();   // hold the sender until every answer is back
            pick      = $urandom_range(99);
            w.element = random_element();
            w.entry   = ENTRY_BITS'($urandom);
            w.last    = 1'b0;
            if (pick < search_pct)
            begin
                w.cmd      = CMD_QUERY;
                w.position = POS_BITS'($urandom_range(active_dims() - 1));
                w.last     = 1'b1;
            end
            else if (pick < search_pct + 35)
            begin
                w.cmd      = CMD_DB;
                w.entry    = ENTRY_BITS'($urandom_range(active_entries() - 1));
                w.position = POS_BITS'($urandom_range(active_dims() - 1));
                w.last     = 1'($urandom);   // last on a database write is ignored
            end
            else if (pick < search_pct + 60)
            begin
                w.cmd      = CMD_QUERY;
                w.position = POS_BITS'($urandom_range(active_dims() - 1));
            end
            else
            begin
                w.cmd      = 1'($urandom);
                w.position = POS_BITS'($urandom);
                w.last     = 1'($urandom);
            end
            issue(w, 1'b0, NO_MATCH);
        end
    endtask

    // ---------------------------------------------------------------- receiver
    // Stall at random; a pending hold-off keeps ready low for its whole count.
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold > 0)
            begin
                m_axis_tready <= 1'b0;
                rx_hold = rx_hold - 1;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // ---------------------------------------------------------------- checker
    task automatic log_miss(input string what, input match_t want, input match_t got);
        mismatch_count++;
        if (report_count < MAX_REPORTS)
        begin
            report_count++;
            $display("[%0t] %s: want idx=%0d found=%0b score=%0d, got idx=%0d found=%0b score=%0d",
                     $realtime, what, want.best_index, want.found, $signed(want.best_score),
                     got.best_index, got.found, $signed(got.best_score));
        end
    endtask

    // Compare each answer transfer against the oldest owed answer.
    always @(posedge clk)
    begin
        match_t got;
        match_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.best_index = m_axis_tdata[ENTRY_BITS-1:0];
            got.best_score = m_axis_tdata[ENTRY_BITS +: ACC_BITS];
            got.found      = m_axis_tuser;
            if (pending_matches.size() == 0)
                log_miss("unexpected answer", NO_MATCH, got);
            else
            begin
                want = pending_matches.pop_front();
                if (got !== want)
                    log_miss("answer mismatch", want, got);
            end
        end
    end

    // ---------------------------------------------------------------- watchdog
    // Count cycles with no transfer on either stream; a long enough run of them
    // means the block hung.
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // ---------------------------------------------------------------- stimulus
    initial
    begin
        logic [CFG_DATA_BITS-1:0] thr_val;
        logic [CFG_DATA_BITS-1:0] ent_val;
        logic [CFG_DATA_BITS-1:0] dim_val;
        int budget;
        int search_pct;

        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = CMD_DB;
        s_axis_tlast   = 1'b0;
        cfg_en         = 1'b0;
        cfg_index      = REG_THRESHOLD;
        cfg_data       = '0;
        mismatch_count = 0;
        report_count   = 0;
        rx_hold        = 0;
        tx_idle_pct    = 19;
        rx_stall_pct   = 19;
        thr_shadow     = THR_RESET;
        nent_shadow    = NENT_RESET;
        ndim_shadow    = NDIM_RESET;

        // Directed table: two one-dimension entries keep every search short.
        // Hand-computed answers stand only where they follow at a glance.
        add_row(reg_row(REG_ENTRIES, 16'd2));
        add_row(reg_row(REG_DIMS, 16'd1));
        add_row(xfer_row(CMD_DB, 0, 0, 32767, 1'b0, 1'b0, NO_MATCH));
        add_row(xfer_row(CMD_DB, 1, 0, -32768, 1'b0, 1'b0, NO_MATCH));
        // top corner of the address space, never searched
        add_row(xfer_row(CMD_DB, 1023, 511, -32768, 1'b0, 1'b0, NO_MATCH));
        add_row(xfer_row(CMD_QUERY, 1023, 511, 32767, 1'b0, 1'b0, NO_MATCH));
        // -1.0 times -1.0 gives the largest score; the default threshold lets it pass
        add_row(xfer_row(CMD_QUERY, 0, 0, -32768, 1'b1, 1'b1, found_at(1, 1073741824)));
        add_row(xfer_row(CMD_QUERY, 0, 0, 32767, 1'b1, 1'b1, found_at(0, 1073676289)));
        // last on a database write starts nothing
        add_row(xfer_row(CMD_DB, 0, 0, 0, 1'b1, 1'b0, NO_MATCH));
        add_row(xfer_row(CMD_QUERY, 0, 0, 0, 1'b1, 1'b1, NO_MATCH));
        // lowest threshold: zero beats -1.0, and the tie keeps the first entry
        add_row(reg_row(REG_THRESHOLD, 16'h8000));
        add_row(xfer_row(CMD_QUERY, 0, 0, 0, 1'b1, 1'b1, found_at(0, 0)));
        // a score equal to the threshold does not pass, one step above does
        add_row(reg_row(REG_THRESHOLD, 16'd100));
        add_row(xfer_row(CMD_DB, 0, 0, -100, 1'b0, 1'b0, NO_MATCH));
        add_row(xfer_row(CMD_DB, 1, 0, -101, 1'b0, 1'b0, NO_MATCH));
        add_row(xfer_row(CMD_QUERY, 0, 0, -32768, 1'b1, 1'b1, found_at(1, 3309568)));
        // highest threshold: only the exact +1.0 score clears it
        add_row(reg_row(REG_THRESHOLD, 16'h7FFF));
        add_row(xfer_row(CMD_QUERY, 0, 0, -32768, 1'b1, 1'b1, NO_MATCH));
        add_row(xfer_row(CMD_DB, 1, 0, -32768, 1'b0, 1'b0, NO_MATCH));
        add_row(xfer_row(CMD_QUERY, 0, 0, -32768, 1'b1, 1'b1, found_at(1, 1073741824)));
        // no entries searched
        add_row(reg_row(REG_ENTRIES, 16'd0));
        add_row(xfer_row(CMD_QUERY, 0, 0, -32768, 1'b1, 1'b1, NO_MATCH));
        // no dimensions: every score is zero
        add_row(reg_row(REG_ENTRIES, 16'd2));
        add_row(reg_row(REG_DIMS, 16'd0));
        add_row(reg_row(REG_THRESHOLD, 16'h8000));
        add_row(xfer_row(CMD_QUERY, 0, 0, 5, 1'b1, 1'b1, found_at(0, 0)));
        add_row(reg_row(REG_THRESHOLD, 16'd0));
        add_row(xfer_row(CMD_QUERY, 0, 0, 5, 1'b1, 1'b1, NO_MATCH));
        // the first entry scores 100 and clears the threshold; the second scores higher and wins
        add_row(reg_row(REG_DIMS, 16'd1));
        add_row(xfer_row(CMD_QUERY, 0, 0, -1, 1'b1, 1'b1, found_at(1, 32768)));

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_CFG)
            begin
                quiesce();
                write_reg(directed_rows[i].reg_index, directed_rows[i].reg_value);
            end
            else
                issue(directed_rows[i].xfer, directed_rows[i].typed, directed_rows[i].want);
        end

        // Random phases: small regions mostly, two at the entry count extreme.
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            budget     = 50;
            search_pct = (ph == PRESSURE_PHASE) ? 40 : 20;
            case (ph)
                0:       thr_val = 16'h8000;
                1:       thr_val = 16'h7FFF;
                default: thr_val = CFG_DATA_BITS'($urandom);
            endcase
            case (ph)
                2:
                begin
                    ent_val = CFG_DATA_BITS'(MAX_ENTRIES);
                    dim_val = 16'd1;
                end
                5:
                begin
                    ent_val = 16'h07FF;             // saturates to the full memory
                    dim_val = 16'd1;
                end
                default:
                begin
                    ent_val = CFG_DATA_BITS'($urandom_range(1, 8));
                    dim_val = CFG_DATA_BITS'($urandom_range(1, 8));
                end
            endcase
            if (ph == 2 || ph == 5)
            begin
                budget     = 40;
                search_pct = 8;
            end
            // bits above each count are outside the register
            ent_val[CFG_DATA_BITS-1:NENT_BITS] = (CFG_DATA_BITS-NENT_BITS)'($urandom);
            dim_val[CFG_DATA_BITS-1:NDIM_BITS] = (CFG_DATA_BITS-NDIM_BITS)'($urandom);

            quiesce();
            write_reg(REG_THRESHOLD, thr_val);
            write_reg(REG_ENTRIES, ent_val);
            write_reg(REG_DIMS, dim_val);

            case (ph % 4)
                0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1:       begin tx_idle_pct = 88; rx_stall_pct = 0;  end
                2:       begin tx_idle_pct = 0;  rx_stall_pct = 88; end
                default: begin tx_idle_pct = 19; rx_stall_pct = 19; end
            endcase

            fill_region();
            // Hold the receiver off while searches keep coming, so the answer
            // register fills and the block stalls its input.
            if (ph == PRESSURE_PHASE)
                rx_hold = HOLD_CYCLES;
            random_traffic(budget, search_pct, ph == PAUSE_PHASE);
        end

        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_matches.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && pending_matches.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> files.f
design/cnns_pkg.sv
design/cosine_nearest_neighbor_search.sv
sim/tb_top.sv
